>>> hw/rtl/xrg_pkg.sv
package xrg_pkg;

   // Request beat: one command with its operands.
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [63:0] seed_value;
      logic [63:0]        clock_seconds;
      logic signed [63:0] range_start;
      logic signed [63:0] range_end;
   } xrg_req_type;

   // Response beat: one result per command.
   typedef struct packed {
      logic signed [63:0] ranged_value;
      logic [63:0]        raw_word;
      logic [52:0]        fraction_bits;
      logic               status;
   } xrg_rsp_type;

   // Command codes.
   localparam logic [1:0] MODE_SEED     = 2'd0;
   localparam logic [1:0] MODE_RANGE    = 2'd1;
   localparam logic [1:0] MODE_FRACTION = 2'd2;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   // Status codes.
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_REVERSED = 1'b1;

   // Generator and seeding constants.
   localparam int          WORD_COUNT  = 4;
   localparam int          DIV_STEPS   = 64;
   localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;
   localparam logic [63:0] SIGN_FLIP   = 64'h8000_0000_0000_0000;

   localparam int MIX_SHIFT_1  = 30;
   localparam int MIX_SHIFT_2  = 27;
   localparam int MIX_SHIFT_3  = 31;
   localparam int SHIFT_W1     = 17;
   localparam int ROT_W3       = 45;
   localparam int ROT_OUT      = 7;
   localparam int FRAC_SHIFT   = 11;

   // 64-bit rotate left by a constant amount.
   function automatic logic [63:0] rotl64(input logic [63:0] v, input int sh);
      rotl64 = (v << sh) | (v >> (64 - sh));
   endfunction

endpackage

>>> hw/rtl/xoshiro256ss_range_generator.sv
// xoshiro256** generator with splitmix64 seeding and ranged integer draws.
// Request channel: a command beat (req_item) is taken at a rising edge where
// start is high and busy is low. busy stays high until the result is out.
// Result channel: rsp_item is valid for exactly one cycle, marked by
// rsp_strobe; the receiver cannot stall, so it must take the beat then.
// The next command can be taken in the same cycle the strobe is shown.
// Work from acceptance to strobe, all done by one shared 65-bit
// adder, one 32x32 multiplier and a small sequencer, one item at a time:
//   seed command      : four splitmix64 words, each two 64-bit
//                       products built from three 32x32 partial products
//   fraction draw     : state advance and raw word only
//   range draw        : adds the 64-step restoring
//                       remainder loop; reversed, equal or full-span
//                       bounds finish without entering the loop
//   unused command    : all-zero result
// Reset clears the sequencer and the strobe only; the generator state is
// undefined until the first seed command and must be seeded before a draw.
module xoshiro256ss_range_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  xrg_pkg::xrg_req_type req_item,
   output logic                 rsp_strobe,
   output xrg_pkg::xrg_rsp_type rsp_item
);
   import xrg_pkg::*;

   // Sequencer state codes.
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_SEED_ADD = 5'd1;
   localparam logic [4:0] ST_SEED_X1  = 5'd2;
   localparam logic [4:0] ST_MUL0     = 5'd3;
   localparam logic [4:0] ST_MUL1     = 5'd4;
   localparam logic [4:0] ST_MUL2     = 5'd5;
   localparam logic [4:0] ST_MUL3     = 5'd6;
   localparam logic [4:0] ST_SEED_X2  = 5'd7;
   localparam logic [4:0] ST_SEED_X3  = 5'd8;
   localparam logic [4:0] ST_DRAW_A   = 5'd9;
   localparam logic [4:0] ST_DRAW_B   = 5'd10;
   localparam logic [4:0] ST_RANGE    = 5'd11;
   localparam logic [4:0] ST_SPAN     = 5'd12;
   localparam logic [4:0] ST_DIV      = 5'd13;
   localparam logic [4:0] ST_FIX      = 5'd14;
   localparam logic [4:0] ST_DONE     = 5'd15;

   logic [4:0]  st_ff, st_in;
   logic        strobe_ff, strobe_in;
   xrg_req_type req_ff, req_in;
   xrg_rsp_type res_ff, res_in;
   logic [63:0] words_ff [WORD_COUNT];
   logic [63:0] words_in [WORD_COUNT];
   logic [1:0]  idx_ff, idx_in;
   logic        phase_ff, phase_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] span_ff, span_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [5:0]  count_ff, count_in;

   // Shared adder/subtractor and multiplier operands.
   logic [64:0] alu_a, alu_b;
   logic        alu_sub;
   logic [65:0] alu_sum;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_const;
   logic [63:0] rot_out;
   logic        seed_positive;

   // Shared 65-bit adder; bit 65 is the carry, which is "no borrow" on subtract.
   assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 66'(alu_sub);

   // Shared 32x32 multiplier, always registered; the upper operand halves are zero.
   assign prod_in   = {32'b0, mul_a} * {32'b0, mul_b};
   assign mul_const = phase_ff ? MIX_MUL_B : MIX_MUL_A;
   assign rot_out   = rotl64(z_ff, ROT_OUT);

   assign seed_positive = !req_item.seed_value[63] && (req_item.seed_value != '0);

   // Multiplier operand selection: low*low, low*high, high*low partial products.
   always_comb begin
      mul_a = z_ff[31:0];
      mul_b = mul_const[31:0];
      case (st_ff)
         ST_MUL1: begin
            mul_b = mul_const[63:32];
         end
         ST_MUL2: begin
            mul_a = z_ff[63:32];
         end
         default: begin
            mul_a = z_ff[31:0];
         end
      endcase
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      st_in     = st_ff;
      strobe_in = 1'b0;
      req_in    = req_ff;
      res_in    = res_ff;
      words_in  = words_ff;
      idx_in    = idx_ff;
      phase_in  = phase_ff;
      x_in      = x_ff;
      z_in      = z_ff;
      acc_in    = acc_ff;
      span_in   = span_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      count_in  = count_ff;
      alu_a     = '0;
      alu_b     = '0;
      alu_sub   = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               res_in = '0;
               idx_in = '0;
               x_in   = seed_positive ? req_item.seed_value : req_item.clock_seconds;
               case (req_item.mode)
                  MODE_SEED:     st_in = ST_SEED_ADD;
                  MODE_RANGE:    st_in = ST_DRAW_A;
                  MODE_FRACTION: st_in = ST_DRAW_A;
                  default:       st_in = ST_DONE;
               endcase
            end
         end

         // Splitmix64: advance the counter word.
         ST_SEED_ADD: begin
            alu_a = {1'b0, x_ff};
            alu_b = {1'b0, GOLDEN_STEP};
            x_in  = alu_sum[63:0];
            z_in  = alu_sum[63:0];
            st_in = ST_SEED_X1;
         end

         ST_SEED_X1: begin
            z_in     = z_ff ^ (z_ff >> MIX_SHIFT_1);
            phase_in = 1'b0;
            st_in    = ST_MUL0;
         end

         // Low 64 bits of z times a 64-bit constant, in states MUL0 to MUL3.
         ST_MUL0: begin
            st_in = ST_MUL1;
         end

         ST_MUL1: begin
            acc_in = prod_ff;
            st_in  = ST_MUL2;
         end

         ST_MUL2: begin
            alu_a  = {1'b0, acc_ff};
            alu_b  = {1'b0, prod_ff[31:0], 32'b0};
            acc_in = alu_sum[63:0];
            st_in  = ST_MUL3;
         end

         ST_MUL3: begin
            alu_a = {1'b0, acc_ff};
            alu_b = {1'b0, prod_ff[31:0], 32'b0};
            z_in  = alu_sum[63:0];
            st_in = phase_ff ? ST_SEED_X3 : ST_SEED_X2;
         end

         ST_SEED_X2: begin
            z_in     = z_ff ^ (z_ff >> MIX_SHIFT_2);
            phase_in = 1'b1;
            st_in    = ST_MUL0;
         end

         // Final mix, store the word and move to the next one.
         ST_SEED_X3: begin
            words_in[idx_ff] = z_ff ^ (z_ff >> MIX_SHIFT_3);
            idx_in           = idx_ff + 2'd1;
            st_in            = (idx_ff == 2'(WORD_COUNT - 1)) ? ST_DONE : ST_SEED_ADD;
         end

         // Advance the state and form w1 * 5.
         ST_DRAW_A: begin
            words_in[0] = words_ff[0] ^ words_ff[3] ^ words_ff[1];
            words_in[1] = words_ff[1] ^ words_ff[2] ^ words_ff[0];
            words_in[2] = words_ff[2] ^ words_ff[0] ^ (words_ff[1] << SHIFT_W1);
            words_in[3] = rotl64(words_ff[3] ^ words_ff[1], ROT_W3);
            alu_a       = {1'b0, words_ff[1]};
            alu_b       = {1'b0, words_ff[1] << 2};
            z_in        = alu_sum[63:0];
            st_in       = ST_DRAW_B;
         end

         // Rotate and multiply by 9 to get the raw word.
         ST_DRAW_B: begin
            alu_a                = {1'b0, rot_out};
            alu_b                = {1'b0, rot_out << 3};
            res_in.raw_word      = alu_sum[63:0];
            res_in.fraction_bits = alu_sum[63:FRAC_SHIFT];
            dvd_in               = alu_sum[63:0];
            st_in                = (req_ff.mode == MODE_RANGE) ? ST_RANGE : ST_DONE;
         end

         // Order the bounds as unsigned keys: end minus start.
         ST_RANGE: begin
            alu_a   = {1'b0, req_ff.range_end ^ SIGN_FLIP};
            alu_b   = {1'b0, req_ff.range_start ^ SIGN_FLIP};
            alu_sub = 1'b1;
            if (!alu_sum[65]) begin
               res_in.status = STATUS_REVERSED;
               st_in         = ST_DONE;
            end else if (alu_sum[63:0] == '0) begin
               res_in.ranged_value = req_ff.range_start;
               st_in               = ST_DONE;
            end else begin
               span_in = alu_sum[63:0];
               st_in   = ST_SPAN;
            end
         end

         // Span is the difference plus one; a wrap to zero means full span.
         ST_SPAN: begin
            alu_a    = {1'b0, span_ff};
            alu_b    = 65'd1;
            rem_in   = '0;
            count_in = '0;
            if (alu_sum[64]) begin
               res_in.ranged_value = res_ff.raw_word;
               st_in               = ST_DONE;
            end else begin
               span_in = alu_sum[63:0];
               st_in   = ST_DIV;
            end
         end

         // Restoring remainder, one dividend bit per cycle.
         ST_DIV: begin
            alu_a    = {rem_ff, dvd_ff[63]};
            alu_b    = {1'b0, span_ff};
            alu_sub  = 1'b1;
            rem_in   = alu_sum[65] ? alu_sum[63:0] : alu_a[63:0];
            dvd_in   = {dvd_ff[62:0], 1'b0};
            count_in = count_ff + 6'd1;
            if (count_ff == 6'(DIV_STEPS - 1)) begin
               st_in = ST_FIX;
            end
         end

         ST_FIX: begin
            alu_a               = {1'b0, req_ff.range_start};
            alu_b               = {1'b0, rem_ff};
            res_in.ranged_value = alu_sum[63:0];
            st_in               = ST_DONE;
         end

         ST_DONE: begin
            strobe_in = 1'b1;
            st_in     = ST_IDLE;
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         strobe_ff <= strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      words_ff <= words_in;
      idx_ff   <= idx_in;
      phase_ff <= phase_in;
      x_ff     <= x_in;
      z_ff     <= z_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      span_ff  <= span_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      count_ff <= count_in;
   end

   assign busy       = (st_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = res_ff;

   // A result beat only follows a command in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a command in progress");

   // Taking a command makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start the sequencer");

   // A reversed interval never reports a ranged value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == STATUS_REVERSED) |-> (rsp_item.ranged_value == '0))
      else $error("reversed interval with nonzero ranged value");

   // The fraction is always the top bits of the raw word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.fraction_bits == rsp_item.raw_word[63:FRAC_SHIFT]))
      else $error("fraction bits do not match raw word");

   // The remainder is below the span once the division loop has finished.
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FIX) |-> (rem_ff < span_ff))
      else $error("remainder not below span");

endmodule
